>>> hw/rtl/ppmtfg_pkg.sv
// ============================================================================
// ppmtfg_pkg
// Shared types and constants for the PPM trainer frame generator: transfer
// payloads, configuration bundle, command codes and register map.
// ============================================================================
`default_nettype none

package ppmtfg_pkg;

    // command codes of an input transfer
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_PACKET = 2'd1;
    localparam logic [1:0] CMD_REJECT = 2'd2;

    // register map, index = paddr / 4
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_FRAME_LEN  = 3'd0;
    localparam logic [2:0] REG_PULSE_W    = 3'd1;
    localparam logic [2:0] REG_SYNC_FB    = 3'd2;
    localparam logic [2:0] REG_WATCHDOG   = 3'd3;
    localparam logic [2:0] REG_ROLL_LIMIT = 3'd4;
    localparam logic [2:0] REG_YAW_LIMIT  = 3'd5;

    // register reset values
    localparam logic [15:0] RST_FRAME_LEN  = 16'd22500;
    localparam logic [9:0]  RST_PULSE_W    = 10'd300;
    localparam logic [15:0] RST_SYNC_FB    = 16'd3000;
    localparam logic [23:0] RST_WATCHDOG   = 24'd250000;
    localparam logic [14:0] RST_ROLL_LIMIT = 15'd2458;
    localparam logic [14:0] RST_YAW_LIMIT  = 15'd2458;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] roll_in;
        logic signed [15:0] pitch_in;
        logic signed [15:0] yaw_in;
        logic signed [15:0] throttle_in;
    } in_t;

    typedef struct packed {
        logic ppm_level;
        logic edge_fired;
        logic link_live;
    } out_t;

    typedef struct packed {
        logic [15:0] frame_length_us;
        logic [9:0]  pulse_width_us;
        logic [15:0] sync_fallback_us;
        logic [23:0] watchdog_ticks;
        logic [14:0] roll_limit;
        logic [14:0] yaw_limit;
    } cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/ppmtfg_cfg_regs.sv
// ============================================================================
// ppmtfg_cfg_regs
// APB-style register file holding the frame timing, watchdog and clamp limits.
// ============================================================================
`default_nettype none

module ppmtfg_cfg_regs (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ppmtfg_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ppmtfg_pkg::DATA_W-1:0] pwdata,
    output logic      [ppmtfg_pkg::DATA_W-1:0] prdata,
    output logic                              pready,
    output ppmtfg_pkg::cfg_t                  cfg
);

    ppmtfg_pkg::cfg_t cfg_reg;
    ppmtfg_pkg::cfg_t cfg_next;
    logic [2:0]       reg_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ppmtfg_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                ppmtfg_pkg::REG_FRAME_LEN:  cfg_next.frame_length_us  = pwdata[15:0];
                ppmtfg_pkg::REG_PULSE_W:    cfg_next.pulse_width_us   = pwdata[9:0];
                ppmtfg_pkg::REG_SYNC_FB:    cfg_next.sync_fallback_us = pwdata[15:0];
                ppmtfg_pkg::REG_WATCHDOG:   cfg_next.watchdog_ticks   = pwdata[23:0];
                ppmtfg_pkg::REG_ROLL_LIMIT: cfg_next.roll_limit       = pwdata[14:0];
                ppmtfg_pkg::REG_YAW_LIMIT:  cfg_next.yaw_limit        = pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            ppmtfg_pkg::REG_FRAME_LEN:  prdata = {16'd0, cfg_reg.frame_length_us};
            ppmtfg_pkg::REG_PULSE_W:    prdata = {22'd0, cfg_reg.pulse_width_us};
            ppmtfg_pkg::REG_SYNC_FB:    prdata = {16'd0, cfg_reg.sync_fallback_us};
            ppmtfg_pkg::REG_WATCHDOG:   prdata = {8'd0, cfg_reg.watchdog_ticks};
            ppmtfg_pkg::REG_ROLL_LIMIT: prdata = {17'd0, cfg_reg.roll_limit};
            ppmtfg_pkg::REG_YAW_LIMIT:  prdata = {17'd0, cfg_reg.yaw_limit};
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_length_us  <= ppmtfg_pkg::RST_FRAME_LEN;
            cfg_reg.pulse_width_us   <= ppmtfg_pkg::RST_PULSE_W;
            cfg_reg.sync_fallback_us <= ppmtfg_pkg::RST_SYNC_FB;
            cfg_reg.watchdog_ticks   <= ppmtfg_pkg::RST_WATCHDOG;
            cfg_reg.roll_limit       <= ppmtfg_pkg::RST_ROLL_LIMIT;
            cfg_reg.yaw_limit        <= ppmtfg_pkg::RST_YAW_LIMIT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ppmtfg_frame_core.sv
// ============================================================================
// ppmtfg_frame_core
// Frame state and single-pass update: edge countdown, slot sequencing,
// sync gap, share offsets and link watchdog.
// ============================================================================
`default_nettype none

module ppmtfg_frame_core #(
    parameter int CHANNELS = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              advance,
    input  ppmtfg_pkg::in_t        item,
    input  ppmtfg_pkg::cfg_t       cfg,
    output ppmtfg_pkg::out_t       result
);

    localparam int SLOT_W = $clog2(CHANNELS + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CHANNELS);
    localparam logic [SLOT_W-1:0] ROLL_SLOT = SLOT_W'(0);
    localparam logic [SLOT_W-1:0] YAW_SLOT  = SLOT_W'(3);
    localparam logic [23:0]       TSP_MAX   = 24'hFFFFFF;
    localparam logic signed [11:0] SLOT_NOMINAL = 12'sd1500;

    // q2.14 share accepted range check
    function automatic logic in_range(input logic signed [15:0] v);
        return (v >= -16'sd16384) && (v <= 16'sd16384);
    endfunction

    function automatic logic signed [16:0] clamp_mag(input logic signed [15:0] v,
                                                     input logic [14:0] lim);
        logic signed [16:0] v17;
        logic signed [16:0] l17;
        v17 = {v[15], v};
        l17 = $signed({2'b00, lim});
        if (v17 > l17) return l17;
        if (v17 < -l17) return -l17;
        return v17;
    endfunction

    // floor(share * 500 / 16384), range -500..500
    function automatic logic signed [9:0] slot_offset(input logic signed [16:0] share);
        logic signed [25:0] prod;
        prod = 26'(share) * 26'sd500;
        return $signed(prod[23:14]);
    endfunction

    function automatic logic [15:0] gap_after(input logic [15:0] total,
                                              input logic [9:0] pw);
        return (total > {6'd0, pw}) ? total - {6'd0, pw} : 16'd1;
    endfunction

    logic               level_reg,     level_next;
    logic [SLOT_W-1:0]  slot_reg,      slot_next;
    logic [15:0]        used_reg,      used_next;
    logic [15:0]        countdown_reg, countdown_next;
    logic signed [9:0]  roll_ofs_reg,  roll_ofs_next;
    logic signed [9:0]  yaw_ofs_reg,   yaw_ofs_next;
    logic [23:0]        tsp_reg,       tsp_next;
    logic               seen_reg,      seen_next;

    logic [23:0]        tsp_inc;
    logic               live_tick;
    logic [15:0]        cd_dec;
    logic signed [9:0]  ofs_sel;
    logic signed [11:0] slot_sum;
    logic [15:0]        slot_len;
    logic [15:0]        sync_total;
    logic               pkt_ok;
    logic               fire;

    always_comb begin
        tsp_inc   = (tsp_reg == TSP_MAX) ? tsp_reg : tsp_reg + 24'd1;
        live_tick = seen_reg && (tsp_inc <= cfg.watchdog_ticks);
        cd_dec    = (countdown_reg != 16'd0) ? countdown_reg - 16'd1 : 16'd0;

        // share of the slot being closed, zero once the watchdog has expired
        if (!live_tick) begin
            ofs_sel = '0;
        end else if (slot_reg == ROLL_SLOT) begin
            ofs_sel = roll_ofs_reg;
        end else if (slot_reg == YAW_SLOT) begin
            ofs_sel = yaw_ofs_reg;
        end else begin
            ofs_sel = '0;
        end
        slot_sum = SLOT_NOMINAL + 12'(ofs_sel);
        slot_len = {5'd0, slot_sum[10:0]};

        sync_total = (cfg.frame_length_us > used_reg) ? cfg.frame_length_us - used_reg
                                                      : cfg.sync_fallback_us;

        pkt_ok = (item.command == ppmtfg_pkg::CMD_PACKET) &&
                 in_range(item.roll_in) && in_range(item.pitch_in) &&
                 in_range(item.yaw_in) && in_range(item.throttle_in);

        level_next     = level_reg;
        slot_next      = slot_reg;
        used_next      = used_reg;
        countdown_next = countdown_reg;
        roll_ofs_next  = roll_ofs_reg;
        yaw_ofs_next   = yaw_ofs_reg;
        tsp_next       = tsp_reg;
        seen_next      = seen_reg;
        fire           = 1'b0;

        if (item.command == ppmtfg_pkg::CMD_TICK) begin
            tsp_next       = tsp_inc;
            countdown_next = cd_dec;
            if (!live_tick) begin
                roll_ofs_next = '0;
                yaw_ofs_next  = '0;
            end
            if (cd_dec == 16'd0) begin
                fire = 1'b1;
                if (!level_reg) begin
                    level_next     = 1'b1;
                    countdown_next = {6'd0, cfg.pulse_width_us};
                end else begin
                    level_next = 1'b0;
                    if (slot_reg < LAST_SLOT) begin
                        slot_next      = slot_reg + SLOT_W'(1);
                        used_next      = used_reg + slot_len;
                        countdown_next = gap_after(slot_len, cfg.pulse_width_us);
                    end else begin
                        slot_next      = '0;
                        used_next      = '0;
                        countdown_next = gap_after(sync_total, cfg.pulse_width_us);
                    end
                end
            end
        end else if (pkt_ok) begin
            roll_ofs_next = slot_offset(clamp_mag(item.roll_in, cfg.roll_limit));
            yaw_ofs_next  = slot_offset(clamp_mag(item.yaw_in, cfg.yaw_limit));
            tsp_next      = '0;
            seen_next     = 1'b1;
        end else begin
            // rejected line or out-of-range packet
            roll_ofs_next = '0;
            yaw_ofs_next  = '0;
        end

        result.ppm_level  = level_next;
        result.edge_fired = fire;
        result.link_live  = seen_next && (tsp_next <= cfg.watchdog_ticks);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg     <= 1'b0;
            slot_reg      <= '0;
            used_reg      <= '0;
            countdown_reg <= '0;
            roll_ofs_reg  <= '0;
            yaw_ofs_reg   <= '0;
            tsp_reg       <= '0;
            seen_reg      <= 1'b0;
        end else if (advance) begin
            level_reg     <= level_next;
            slot_reg      <= slot_next;
            used_reg      <= used_next;
            countdown_reg <= countdown_next;
            roll_ofs_reg  <= roll_ofs_next;
            yaw_ofs_reg   <= yaw_ofs_next;
            tsp_reg       <= tsp_next;
            seen_reg      <= seen_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/ppm_trainer_frame_generator_unit.sv
// ============================================================================
// ppm_trainer_frame_generator_unit
// Multi-channel PPM trainer frame generator driven by a 1 us tick stream.
// ============================================================================
// usage
//   s_ channel: one transfer per item; command 0 is a 1 us tick, command 1 a
//   parsed packet carrying roll/pitch/yaw/throttle in q2.14, command 2 or 3
//   a rejected line. every accepted transfer yields exactly one m_ transfer
//   with the pin level, an edge flag and the link status.
//   apb port: six registers at byte offsets 0x00..0x14 (frame length, marker
//   width, sync fallback, watchdog, roll limit, yaw limit); write only while
//   no item is in flight.
// timing
//   an s_ transfer is held in the input register, then the single-pass frame
//   update loads the result register that drives m_valid.
//   throughput is one item per cycle unless stalled; the update path (offset
//   select, slot length add, gap subtract and compare) alone limits it.
// reset
//   synchronous, active low: pipeline empty, pin low with an edge on the
//   first tick, shares zero, link down, registers at their defaults.
// stall
//   while m_ready is low the result holds; the input register still takes
//   one more transfer, after which s_ready drops until the result leaves.
// ============================================================================
`default_nettype none

module ppm_trainer_frame_generator_unit #(
    parameter int CHANNELS = 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  ppmtfg_pkg::in_t                    s_data,
    // result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output ppmtfg_pkg::out_t                   m_data,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ppmtfg_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ppmtfg_pkg::DATA_W-1:0] pwdata,
    output logic      [ppmtfg_pkg::DATA_W-1:0] prdata,
    output logic                               pready
);

    ppmtfg_pkg::cfg_t cfg;
    ppmtfg_pkg::in_t  stage_item_reg;
    ppmtfg_pkg::out_t result;
    ppmtfg_pkg::out_t m_data_reg;
    logic             stage_valid_reg, stage_valid_next;
    logic             m_valid_reg,     m_valid_next;
    logic             advance;
    logic             s_fire;

    ppmtfg_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // the held item moves into the result register when that register is
    // empty or its transfer completes this cycle
    assign advance = stage_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !stage_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    ppmtfg_frame_core #(
        .CHANNELS (CHANNELS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (stage_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_comb begin
        stage_valid_next = stage_valid_reg;
        if (s_fire) begin
            stage_valid_next = 1'b1;
        end else if (advance) begin
            stage_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            stage_item_reg <= s_data;
        end
        if (advance) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // packets and rejected lines never move the pin
    a_no_edge_on_packet: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && stage_item_reg.command != ppmtfg_pkg::CMD_TICK) |=> !m_data_reg.edge_fired)
        else $error("edge reported for a non-tick item");

    // an item leaving the input register always lands in the result register
    a_advance_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg)
        else $error("advanced item did not produce a result");

    // an empty input register must always take a transfer
    a_empty_stage_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !stage_valid_reg |-> s_ready)
        else $error("input stage empty but not ready");

endmodule

`default_nettype wire
